// ----- src/per_bucket_token_policer_assert.svh -----
// ----------------------------------------------------------------------------
// Token bucket policer assertion macros
// Concurrent checks that simulation evaluates and synthesis drops.
// ----------------------------------------------------------------------------
`ifndef PER_BUCKET_TOKEN_POLICER_ASSERT_SVH
`define PER_BUCKET_TOKEN_POLICER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define TBP_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("policer same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define TBP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("policer next-cycle check failed");

`else

`define TBP_ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define TBP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ----- src/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Token bucket policer package
// Field widths, constants and the types shared between the policer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

    localparam int IDX_W   = 12;
    localparam int RATE_W  = 37;
    localparam int LEN_W   = 16;
    localparam int TIME_W  = 64;
    localparam int TOK_W   = 40;
    localparam int BYTES_W = 64;
    localparam int WIN_W   = 30;

    localparam int BUCKET_COUNT_DEFAULT = 4096;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 30'd10000000;
    localparam logic [29:0]      NS_PER_SEC   = 30'd1000000000;
    localparam logic [TOK_W-1:0] BURST_FLOOR  = 40'd1500;

    typedef enum logic {
        KIND_UNLIMITED,
        KIND_POLICED
    } kind_t;

    // One classified packet on its way from the front to the back.
    typedef struct packed {
        kind_t              kind;
        logic [IDX_W-1:0]   index;
        logic [RATE_W-1:0]  rate;
        logic [LEN_W-1:0]   length;
        logic [TIME_W-1:0]  now;
    } item_t;

    // One bucket as it is stored in the table.
    typedef struct packed {
        logic               valid;
        logic [TOK_W-1:0]   tokens;
        logic [TIME_W-1:0]  last_time;
        logic [BYTES_W-1:0] passed;
    } entry_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  a;
        logic [RATE_W-1:0]  b;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic [TIME_W-1:0]  result;
    } md_rsp_t;

endpackage

`default_nettype wire

// ----- src/tbp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/tbp_muldiv.sv -----
// ----------------------------------------------------------------------------
// Token bucket policer multiply-divide unit
// Computes floor(a * b / 1e9) saturated to 64 bits, multiplying in chunks and then dividing.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_muldiv (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbp_pkg::md_req_t req,
    output tbp_pkg::md_rsp_t rsp
);

    import tbp_pkg::*;

    localparam int CHUNK_W   = 16;
    localparam int B_PAD_W   = ((RATE_W + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int MUL_STEPS = B_PAD_W / CHUNK_W;
    localparam int PP_W      = TIME_W + CHUNK_W;
    localparam int DIV_BITS  = 4;
    localparam int PROD_W    = ((TIME_W + RATE_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int REM_W     = $bits(NS_PER_SEC);

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_state_t;

    md_state_t           state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [TIME_W-1:0]   a_reg, a_next;
    logic [B_PAD_W-1:0]  b_reg, b_next;
    logic [PROD_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]    rem_reg, rem_next;

    logic [PP_W-1:0]     pp;
    logic [PROD_W-1:0]   div_acc;
    logic [REM_W-1:0]    div_rem;

    assign pp = PP_W'(a_reg) * PP_W'(b_reg[B_PAD_W-1 -: CHUNK_W]);

    // Restoring division by the constant, DIV_BITS quotient bits per cycle.
    // The dividend shifts out at the top while quotient bits enter at the bottom.
    always_comb begin
        logic [REM_W:0] trial;
        div_acc = acc_reg;
        div_rem = rem_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial   = {div_rem, div_acc[PROD_W-1]};
            div_acc = div_acc << 1;
            if (trial >= {1'b0, NS_PER_SEC}) begin
                div_rem    = REM_W'(trial - {1'b0, NS_PER_SEC});
                div_acc[0] = 1'b1;
            end else begin
                div_rem = trial[REM_W-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            MD_IDLE, MD_DONE: begin
                if (req.start) begin
                    a_next     = req.a;
                    b_next     = B_PAD_W'(req.b);
                    acc_next   = '0;
                    cnt_next   = CNT_W'(MUL_STEPS - 1);
                    state_next = MD_MUL;
                end else begin
                    state_next = MD_IDLE;
                end
            end
            MD_MUL: begin
                acc_next = (acc_reg << CHUNK_W) + PROD_W'(pp);
                b_next   = b_reg << CHUNK_W;
                if (cnt_reg == '0) begin
                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                    rem_next   = '0;
                    state_next = MD_DIV;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            MD_DIV: begin
                acc_next = div_acc;
                rem_next = div_rem;
                if (cnt_reg == '0) begin
                    state_next = MD_DONE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            state_reg <= MD_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign rsp.done   = (state_reg == MD_DONE);
    assign rsp.result = (|acc_reg[PROD_W-1:TIME_W]) ? '1 : acc_reg[TIME_W-1:0];

endmodule

`default_nettype wire

// ----- src/tbp_front.sv -----
// ----------------------------------------------------------------------------
// Token bucket policer front end
// Accepts packets, folds the bucket index into the table and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_front #(
    parameter int BUCKET_COUNT = tbp_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tbp_pkg::IDX_W-1:0]   s_bucket_index,
    input  logic [tbp_pkg::RATE_W-1:0]  s_rate_bytes_per_sec,
    input  logic [tbp_pkg::LEN_W-1:0]   s_packet_length,
    input  logic [tbp_pkg::TIME_W-1:0]  s_now_ns,
    output logic                        out_valid,
    input  logic                        out_ready,
    output tbp_pkg::item_t              out_item
);

    import tbp_pkg::*;

    localparam int INDEX_SPAN = 1 << IDX_W;
    localparam int MOD_STEPS  = (BUCKET_COUNT >= INDEX_SPAN) ? 1 :
                                $clog2(INDEX_SPAN / BUCKET_COUNT) + 1;
    localparam int DIV_W      = $clog2(BUCKET_COUNT) + MOD_STEPS + 1;
    localparam int STEP_W     = $clog2(MOD_STEPS + 1);

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_REDUCE,
        FR_PUSH
    } fr_state_t;

    fr_state_t          state_reg, state_next;
    item_t              item_reg, item_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    // The index is reduced modulo the table size by shift-and-subtract,
    // one shifted copy of the table size per cycle.
    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        unique case (state_reg)
            FR_IDLE: begin
                if (s_valid) begin
                    item_next.kind   = (s_rate_bytes_per_sec == '0) ? KIND_UNLIMITED
                                                                     : KIND_POLICED;
                    item_next.index  = s_bucket_index;
                    item_next.rate   = s_rate_bytes_per_sec;
                    item_next.length = s_packet_length;
                    item_next.now    = s_now_ns;
                    div_next         = DIV_W'(BUCKET_COUNT) << (MOD_STEPS - 1);
                    step_next        = STEP_W'(MOD_STEPS - 1);
                    state_next       = FR_REDUCE;
                end
            end
            FR_REDUCE: begin
                if (DIV_W'(item_reg.index) >= div_reg) begin
                    item_next.index = item_reg.index - IDX_W'(div_reg);
                end
                div_next = div_reg >> 1;
                if (step_reg == '0) begin
                    state_next = FR_PUSH;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            FR_PUSH: begin
                if (out_ready) begin
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        div_reg  <= div_next;
        step_reg <= step_next;
        if (!aresetn) begin
            state_reg <= FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready   = (state_reg == FR_IDLE);
    assign out_valid = (state_reg == FR_PUSH);
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ----- src/tbp_queue.sv -----
// ----------------------------------------------------------------------------
// Token bucket policer item queue
// Short FIFO that decouples the front end from the bucket engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tbp_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output tbp_pkg::item_t out_item
);

    import tbp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/tbp_back.sv -----
// ----------------------------------------------------------------------------
// Token bucket policer bucket engine
// Reads, refills, charges and writes back one bucket per policed packet.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_back #(
    parameter int BUCKET_COUNT = tbp_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tbp_pkg::WIN_W-1:0]   burst_window,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  tbp_pkg::item_t              q_item,
    output logic                        clearing,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pass_packet,
    output logic [tbp_pkg::TOK_W-1:0]   m_tokens_left,
    output logic [tbp_pkg::BYTES_W-1:0] m_bucket_bytes
);

    import tbp_pkg::*;

    localparam int AW = $clog2(BUCKET_COUNT);
    localparam int EW = $bits(entry_t);

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_BURST,
        BK_REFILL,
        BK_PAY,
        BK_FINISH
    } bk_state_t;

    bk_state_t           state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    item_t               item_reg, item_next;
    logic [TOK_W-1:0]    burst_reg, burst_next;
    logic [TOK_W-1:0]    tok_reg, tok_next;
    logic                res_pass_reg, res_pass_next;
    logic [TOK_W-1:0]    res_tokens_reg, res_tokens_next;
    logic [BYTES_W-1:0]  res_bytes_reg, res_bytes_next;
    logic                wr_flag_reg, wr_flag_next;
    entry_t              wr_entry_reg, wr_entry_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_pass_reg, m_pass_next;
    logic [TOK_W-1:0]    m_tokens_reg, m_tokens_next;
    logic [BYTES_W-1:0]  m_bytes_reg, m_bytes_next;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    entry_t              ram_wr_data, ram_rd_data;
    logic [EW-1:0]       ram_rd_bits;
    md_req_t             md_req;
    md_rsp_t             md_rsp;

    logic [TOK_W-1:0]    burst_raw, burst_val;
    logic [TIME_W-1:0]   elapsed;
    logic [TOK_W:0]      refill_sum_hi;
    logic [TIME_W:0]     refill_sum;
    logic [TOK_W-1:0]    cost;
    logic                out_free;

    tbp_ram #(
        .WIDTH (EW),
        .DEPTH (BUCKET_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (EW'(ram_wr_data)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_bits)
    );

    assign ram_rd_data = entry_t'(ram_rd_bits);

    tbp_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign burst_raw     = md_rsp.result[TOK_W-1:0];
    assign burst_val     = (burst_raw < BURST_FLOOR) ? BURST_FLOOR : burst_raw;
    assign elapsed       = item_reg.now - ram_rd_data.last_time;
    assign refill_sum    = {1'b0, md_rsp.result} + (TIME_W + 1)'(ram_rd_data.tokens);
    assign refill_sum_hi = (TOK_W + 1)'(burst_reg);
    assign cost          = TOK_W'(item_reg.length);
    assign out_free      = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        item_next       = item_reg;
        burst_next      = burst_reg;
        tok_next        = tok_reg;
        res_pass_next   = res_pass_reg;
        res_tokens_next = res_tokens_reg;
        res_bytes_next  = res_bytes_reg;
        wr_flag_next    = wr_flag_reg;
        wr_entry_next   = wr_entry_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_pass_next     = m_pass_reg;
        m_tokens_next   = m_tokens_reg;
        m_bytes_next    = m_bytes_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = clr_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(q_item.index);
        q_ready     = 1'b0;
        md_req.start = 1'b0;
        md_req.a     = TIME_W'(q_item.rate);
        md_req.b     = RATE_W'(burst_window);

        unique case (state_reg)
            BK_CLEAR: begin
                ram_wr_en = 1'b1;
                if (clr_reg == AW'(BUCKET_COUNT - 1)) begin
                    state_next = BK_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next = q_item;
                    if (q_item.kind == KIND_POLICED) begin
                        ram_rd_en    = 1'b1;
                        md_req.start = 1'b1;
                        state_next   = BK_BURST;
                    end else begin
                        res_pass_next   = 1'b1;
                        res_tokens_next = '0;
                        res_bytes_next  = '0;
                        wr_flag_next    = 1'b0;
                        state_next      = BK_FINISH;
                    end
                end
            end
            BK_BURST: begin
                if (md_rsp.done) begin
                    burst_next = burst_val;
                    if (!ram_rd_data.valid) begin
                        if (cost > burst_val) begin
                            res_pass_next   = 1'b0;
                            res_tokens_next = '0;
                            res_bytes_next  = '0;
                            wr_flag_next    = 1'b0;
                        end else begin
                            res_pass_next           = 1'b1;
                            res_tokens_next         = burst_val - cost;
                            res_bytes_next          = BYTES_W'(item_reg.length);
                            wr_flag_next            = 1'b1;
                            wr_entry_next.valid     = 1'b1;
                            wr_entry_next.tokens    = burst_val - cost;
                            wr_entry_next.last_time = item_reg.now;
                            wr_entry_next.passed    = BYTES_W'(item_reg.length);
                        end
                        state_next = BK_FINISH;
                    end else if (elapsed != '0) begin
                        md_req.start = 1'b1;
                        md_req.a     = elapsed;
                        md_req.b     = item_reg.rate;
                        state_next   = BK_REFILL;
                    end else begin
                        // No time has passed: tokens stay as stored, even above the burst.
                        tok_next   = ram_rd_data.tokens;
                        state_next = BK_PAY;
                    end
                end
            end
            BK_REFILL: begin
                if (md_rsp.done) begin
                    if (refill_sum > (TIME_W + 1)'(refill_sum_hi)) begin
                        tok_next = burst_reg;
                    end else begin
                        tok_next = refill_sum[TOK_W-1:0];
                    end
                    state_next = BK_PAY;
                end
            end
            BK_PAY: begin
                wr_flag_next            = 1'b1;
                wr_entry_next.valid     = 1'b1;
                wr_entry_next.last_time = item_reg.now;
                if (tok_reg >= cost) begin
                    res_pass_next        = 1'b1;
                    res_tokens_next      = tok_reg - cost;
                    res_bytes_next       = ram_rd_data.passed + BYTES_W'(item_reg.length);
                    wr_entry_next.tokens = tok_reg - cost;
                    wr_entry_next.passed = ram_rd_data.passed + BYTES_W'(item_reg.length);
                end else begin
                    res_pass_next        = 1'b0;
                    res_tokens_next      = tok_reg;
                    res_bytes_next       = ram_rd_data.passed;
                    wr_entry_next.tokens = tok_reg;
                    wr_entry_next.passed = ram_rd_data.passed;
                end
                state_next = BK_FINISH;
            end
            BK_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_pass_next   = res_pass_reg;
                    m_tokens_next = res_tokens_reg;
                    m_bytes_next  = res_bytes_reg;
                    ram_wr_en     = wr_flag_reg;
                    ram_wr_addr   = AW'(item_reg.index);
                    ram_wr_data   = wr_entry_reg;
                    state_next    = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        burst_reg      <= burst_next;
        tok_reg        <= tok_next;
        res_pass_reg   <= res_pass_next;
        res_tokens_reg <= res_tokens_next;
        res_bytes_reg  <= res_bytes_next;
        wr_flag_reg    <= wr_flag_next;
        wr_entry_reg   <= wr_entry_next;
        m_pass_reg     <= m_pass_next;
        m_tokens_reg   <= m_tokens_next;
        m_bytes_reg    <= m_bytes_next;
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign clearing       = (state_reg == BK_CLEAR);
    assign m_valid        = m_valid_reg;
    assign m_pass_packet  = m_pass_reg;
    assign m_tokens_left  = m_tokens_reg;
    assign m_bucket_bytes = m_bytes_reg;

endmodule

`default_nettype wire

// ----- src/per_bucket_token_policer.sv -----
// ----------------------------------------------------------------------------
// Per-bucket token bucket policer
// Polices packets against a table of token buckets, one result per packet.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_bucket_token_policer_assert.svh"

// Each packet names a bucket, its allowed rate in bytes per second, its length
// and the current time in ns, and gets one result: pass or drop, the tokens
// left in the bucket and the running total of bytes passed in it. The bucket
// depth is rate times burst_window_ns over 1e9, with a floor of 1500 bytes,
// and a rate of zero always passes without touching the table. After reset
// the engine sweeps the bucket table once to clear it; packets are buffered
// by the front end and the queue during that sweep but produce no results
// until it ends. A policed packet needs one pass through the shared
// multiply-divide unit for its bucket depth and another when its bucket has
// to be refilled (3 multiply steps and 26 radix-16 division steps by 1e9 per
// pass). The front end folds the bucket index into the table before the
// engine sees the packet, and that work overlaps with the engine. Packets
// are handled strictly one at a time in the engine, so results leave in the
// order the packets arrived. The burst window register may only be written
// while no packet is in flight.
module per_bucket_token_policer #(
    parameter int BUCKET_COUNT = tbp_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    // Burst window register write port.
    input  logic                        cfg_wr_en,
    input  logic [tbp_pkg::WIN_W-1:0]   cfg_wr_data,

    // Packet channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tbp_pkg::IDX_W-1:0]   s_bucket_index,
    input  logic [tbp_pkg::RATE_W-1:0]  s_rate_bytes_per_sec,
    input  logic [tbp_pkg::LEN_W-1:0]   s_packet_length,
    input  logic [tbp_pkg::TIME_W-1:0]  s_now_ns,

    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pass_packet,
    output logic [tbp_pkg::TOK_W-1:0]   m_tokens_left,
    output logic [tbp_pkg::BYTES_W-1:0] m_bucket_bytes
);

    import tbp_pkg::*;

    logic [WIN_W-1:0] window_reg;

    logic  q_in_valid, q_in_ready;
    logic  q_out_valid, q_out_ready;
    item_t q_in_item, q_out_item;
    logic  clearing;

    // The burst window is a plain write-only register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    // Front end: takes a packet, reduces its bucket index to the table size
    // and marks it as unlimited or policed.
    tbp_front #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_bucket_index       (s_bucket_index),
        .s_rate_bytes_per_sec (s_rate_bytes_per_sec),
        .s_packet_length      (s_packet_length),
        .s_now_ns             (s_now_ns),
        .out_valid            (q_in_valid),
        .out_ready            (q_in_ready),
        .out_item             (q_in_item)
    );

    // The queue lets the front end keep taking packets while the engine
    // is busy with a long refill computation.
    tbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_item   (q_in_item),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_item  (q_out_item)
    );

    // Engine: owns the bucket table and the multiply-divide unit, and holds
    // each result in an output register so it can move on while the result
    // waits to be taken.
    tbp_back #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .burst_window   (window_reg),
        .q_valid        (q_out_valid),
        .q_ready        (q_out_ready),
        .q_item         (q_out_item),
        .clearing       (clearing),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pass_packet  (m_pass_packet),
        .m_tokens_left  (m_tokens_left),
        .m_bucket_bytes (m_bucket_bytes)
    );

    // The engine must not take a packet while the table is being cleared.
    `TBP_ASSERT_IMPLIES(a_no_pop_while_clearing, aclk, aresetn, clearing, !q_out_ready)
    // No result can appear before the table sweep after reset has ended.
    `TBP_ASSERT_IMPLIES(a_no_result_while_clearing, aclk, aresetn, clearing, !m_valid)
    // The front end works on one packet at a time.
    `TBP_ASSERT_NEXT(a_front_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

`default_nettype wire
